### rtl/core/twbl_pkg.sv
// twbl_pkg: shared constants, codes and types of the two-class batch loader
// used by twbl_sched, the top level and twbl_checker; depends on nothing
package twbl_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int AW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 10;
  localparam int RUN_W       = 4;
  localparam int CAP_W       = 6;
  localparam int SLOT_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int TDATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_RUN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOODS_RUN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOAT_CAPACITY = 2'd2;

  localparam logic [RUN_W-1:0] PRIORITY_RUN_RST  = 4'd4;
  localparam logic [RUN_W-1:0] GOODS_RUN_RST     = 4'd1;
  localparam logic [CAP_W-1:0] BOAT_CAPACITY_RST = 6'd10;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  localparam logic KIND_PRIORITY = 1'b0;
  localparam logic KIND_OTHER    = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_LOADED   = 2'd2,
    ST_NOTHING  = 2'd3
  } status_t;

  // write request to the two queue memories
  typedef struct packed {
    logic            p_we;
    logic            o_we;
    logic [AW-1:0]   addr;
    logic [ID_W-1:0] data;
  } qwr_t;

  // outcome of the item being accepted
  typedef struct packed {
    status_t status;
    logic    kind;
    logic    last;
  } qres_t;

endpackage

### rtl/core/twbl_ram.sv
// twbl_ram: generic single-write, single-read synchronous memory
// registered read data; no dependencies
module twbl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/twbl_sched.sv
// twbl_sched: config registers, queue pointers and counts, weighted slot
// and batch bookkeeping; depends on twbl_pkg
module twbl_sched
  import twbl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  go,
  input  logic                  action,
  input  logic [ID_W-1:0]       vehicle_id,
  input  logic                  vehicle_kind,
  output qwr_t                  wr,
  output logic [AW-1:0]         p_head,
  output logic [AW-1:0]         o_head,
  output qres_t                 res
);

  logic [RUN_W-1:0]  priority_run;
  logic [RUN_W-1:0]  goods_run;
  logic [CAP_W-1:0]  boat_capacity;
  logic [CW-1:0]     p_count, p_count_next;
  logic [CW-1:0]     o_count, o_count_next;
  logic [AW-1:0]     p_head_next, o_head_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [CAP_W-1:0]  fill, fill_next;

  logic [RUN_W-1:0]  pr_eff, gr_eff;
  logic [CAP_W-1:0]  cap_eff;
  logic [SLOT_W-1:0] cycle_len, slot_a, slot_b;
  logic              take_p, both_empty, drain, sel_full;
  logic [CW-1:0]     sel_count;
  logic [AW-1:0]     sel_head;
  logic [AW:0]       tail_sum;
  logic [CAP_W-1:0]  fill_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_run  <= PRIORITY_RUN_RST;
      goods_run     <= GOODS_RUN_RST;
      boat_capacity <= BOAT_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRIORITY_RUN:  priority_run  <= cfg_data[RUN_W-1:0];
        CFG_GOODS_RUN:     goods_run     <= cfg_data[RUN_W-1:0];
        CFG_BOAT_CAPACITY: boat_capacity <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pr_eff     = (priority_run == '0) ? RUN_W'(1) : priority_run;
    gr_eff     = (goods_run == '0) ? RUN_W'(1) : goods_run;
    cap_eff    = (boat_capacity == '0) ? CAP_W'(1) : boat_capacity;
    cycle_len  = {1'b0, pr_eff} + {1'b0, gr_eff};
    both_empty = (p_count == '0) && (o_count == '0);

    slot_a = (slot >= cycle_len) ? '0 : slot;
    slot_b = (slot_a >= {1'b0, pr_eff} && o_count == '0) ? '0 : slot_a;
    take_p = (slot_b < {1'b0, pr_eff}) && (p_count != '0);
    drain  = take_p ? (p_count == CW'(1) && o_count == '0)
                    : (o_count == CW'(1) && p_count == '0);
    fill_inc = fill + CAP_W'(1);

    // tail of the queue named by the item
    sel_count = vehicle_kind ? o_count : p_count;
    sel_head  = vehicle_kind ? o_head : p_head;
    sel_full  = (sel_count == CW'(QUEUE_DEPTH));
    tail_sum  = {1'b0, sel_head} + {1'b0, sel_count[AW-1:0]};
    if (tail_sum >= (AW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (AW+1)'(QUEUE_DEPTH);
    end

    wr.p_we = go && (action == ACT_ENQUEUE) && !sel_full && (vehicle_kind == KIND_PRIORITY);
    wr.o_we = go && (action == ACT_ENQUEUE) && !sel_full && (vehicle_kind == KIND_OTHER);
    wr.addr = tail_sum[AW-1:0];
    wr.data = vehicle_id;

    res.kind = KIND_PRIORITY;
    res.last = 1'b0;
    if (action == ACT_ENQUEUE) begin
      res.status = sel_full ? ST_DROPPED : ST_ENQUEUED;
    end else if (both_empty) begin
      res.status = ST_NOTHING;
    end else begin
      res.status = ST_LOADED;
      res.kind   = take_p ? KIND_PRIORITY : KIND_OTHER;
      res.last   = (fill_inc >= cap_eff) || drain;
    end

    p_count_next = p_count;
    o_count_next = o_count;
    p_head_next  = p_head;
    o_head_next  = o_head;
    slot_next    = slot;
    fill_next    = fill;
    if (go) begin
      if (action == ACT_ENQUEUE) begin
        if (wr.p_we) p_count_next = p_count + CW'(1);
        if (wr.o_we) o_count_next = o_count + CW'(1);
      end else if (!both_empty) begin
        if (take_p) begin
          p_count_next = p_count - CW'(1);
          p_head_next  = (p_head == AW'(QUEUE_DEPTH - 1)) ? '0 : p_head + AW'(1);
        end else begin
          o_count_next = o_count - CW'(1);
          o_head_next  = (o_head == AW'(QUEUE_DEPTH - 1)) ? '0 : o_head + AW'(1);
        end
        if (res.last) begin
          slot_next = '0;
          fill_next = '0;
        end else begin
          slot_next = slot_b + SLOT_W'(1);
          fill_next = fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_count <= '0;
      o_count <= '0;
      p_head  <= '0;
      o_head  <= '0;
      slot    <= '0;
      fill    <= '0;
    end else begin
      p_count <= p_count_next;
      o_count <= o_count_next;
      p_head  <= p_head_next;
      o_head  <= o_head_next;
      slot    <= slot_next;
      fill    <= fill_next;
    end
  end

endmodule

### rtl/core/two_class_weighted_batch_loader_unit.sv
// two_class_weighted_batch_loader_unit: top level of the two-class batch loader
// depends on twbl_pkg, twbl_ram and twbl_sched
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: vehicle_id; tuser: action, vehicle_kind
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: loaded_id; tuser: status, loaded_kind;
//                                            tlast: last_in_batch
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// an enqueue, or a load with both queues empty, is answered straight from the output
// register; a load first passes S_READ for the registered read of the queue memory at the head pointer
// one beat in flight at a time; a new beat is taken only when the output
// register is empty or hands its beat over in the same cycle
// synchronous reset empties both queues; memory contents need no clearing
// cfg writes are always taken, and are meant only while the block is idle
module two_class_weighted_batch_loader_unit
  import twbl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,  // [9:0] vehicle_id
  input  logic [1:0]            s_axis_tuser,  // [0] action, [1] vehicle_kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,  // [9:0] loaded_id
  output logic [2:0]            m_axis_tuser,  // [1:0] status, [2] loaded_kind
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t          state;
  logic            go;
  qwr_t            wr;
  qres_t           res;
  logic [AW-1:0]   p_head, o_head;
  logic [ID_W-1:0] p_rdata, o_rdata;
  logic            pend_kind;
  logic            pend_last;
  status_t         out_status;
  logic [ID_W-1:0] out_id;
  logic            out_kind;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign go            = s_axis_tvalid && s_axis_tready;

  twbl_sched u_sched (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .go           (go),
    .action       (s_axis_tuser[0]),
    .vehicle_id   (s_axis_tdata[ID_W-1:0]),
    .vehicle_kind (s_axis_tuser[1]),
    .wr           (wr),
    .p_head       (p_head),
    .o_head       (o_head),
    .res          (res)
  );

  twbl_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_W)) u_p_ram (
    .clk   (clk),
    .we    (wr.p_we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (p_head),
    .rdata (p_rdata)
  );

  twbl_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_W)) u_o_ram (
    .clk   (clk),
    .we    (wr.o_we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (o_head),
    .rdata (o_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            out_status   <= res.status;
            out_id       <= '0;
            out_kind     <= res.kind;
            m_axis_tlast <= res.last;
            pend_kind    <= res.kind;
            pend_last    <= res.last;
            if (res.status == ST_LOADED) begin
              state         <= S_READ;
              m_axis_tvalid <= 1'b0;
            end else begin
              m_axis_tvalid <= 1'b1;
            end
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
        end
        S_READ: begin
          out_id        <= (pend_kind == KIND_OTHER) ? o_rdata : p_rdata;
          out_kind      <= pend_kind;
          m_axis_tlast  <= pend_last;
          m_axis_tvalid <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {{(TDATA_W - ID_W){1'b0}}, out_id};
  assign m_axis_tuser = {out_kind, out_status};

endmodule

### rtl/core/twbl_checker.sv
// twbl_checker: port-level assertions for the two-class batch loader
// depends on twbl_pkg; bound to two_class_weighted_batch_loader_unit
module twbl_checker
  import twbl_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [1:0]         s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]         m_axis_tuser,
  input logic               m_axis_tlast
);

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat withdrawn before taken");

  // anything but a load carries zero id, kind and last
  a_nonload_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1:0] != ST_LOADED |->
      m_axis_tdata == '0 && !m_axis_tuser[2] && !m_axis_tlast)
    else $error("non-load beat with load payload");

  // an enqueue beat answers in the next cycle with an enqueue status
  a_enq_answer: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == ACT_ENQUEUE |=>
      m_axis_tvalid &&
      (m_axis_tuser[1:0] == ST_ENQUEUED || m_axis_tuser[1:0] == ST_DROPPED))
    else $error("enqueue beat without enqueue result");

endmodule

bind two_class_weighted_batch_loader_unit twbl_checker u_twbl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
